>>> sv/pcd_pkg.sv
// Shared types, constants and codes for the pushbuffer command decoder.
package pcd_pkg;

	localparam int WORD_W  = 32;
	localparam int METH_W  = 11;
	localparam int SUBCH_W = 3;
	localparam int COUNT_W = 11;
	localparam int ERR_W   = 3;

	// Output beat packing
	localparam int OUT_FIELDS_W = WORD_W + METH_W + SUBCH_W + 1 + WORD_W + COUNT_W + ERR_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FETCH_LIMIT   = 1'b1;

	localparam logic [WORD_W-1:0] START_ADDRESS_RST = 32'h0000_0000;
	localparam logic [WORD_W-1:0] FETCH_LIMIT_RST   = 32'hffff_ffff;

	// Header decode masks and patterns
	localparam logic [WORD_W-1:0] OLD_JUMP_MASK = 32'he000_0003;
	localparam logic [WORD_W-1:0] OLD_JUMP_PAT  = 32'h2000_0000;
	localparam logic [WORD_W-1:0] OLD_JUMP_ADDR = 32'h1fff_ffff;
	localparam logic [WORD_W-1:0] ALIGN_MASK    = 32'hffff_fffc;
	localparam logic [WORD_W-1:0] RETURN_WORD   = 32'h0002_0000;
	localparam logic [WORD_W-1:0] METHOD_MASK   = 32'he003_0003;
	localparam logic [WORD_W-1:0] INC_PAT       = 32'h0000_0000;
	localparam logic [WORD_W-1:0] NONINC_PAT    = 32'h4000_0000;
	localparam logic [1:0]        TAG_JUMP      = 2'd1;
	localparam logic [1:0]        TAG_CALL      = 2'd2;
	localparam logic [WORD_W-1:0] FETCH_STEP    = 32'd4;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE       = 3'd0,
		ERR_PROTECTION = 3'd1,
		ERR_NESTED     = 3'd2,
		ERR_NO_CALL    = 3'd3,
		ERR_RESERVED   = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		HDR_OLD_JUMP,
		HDR_JUMP,
		HDR_CALL,
		HDR_RETURN,
		HDR_INC,
		HDR_NONINC,
		HDR_RESERVED
	} hdr_kind_t;

	typedef struct packed {
		logic [WORD_W-1:0]  next_fetch_address;
		logic               method_valid;
		logic [METH_W-1:0]  method_word_address;
		logic [SUBCH_W-1:0] subch_id;
		logic               non_incrementing;
		logic [WORD_W-1:0]  method_data;
		logic [COUNT_W-1:0] data_count;
		err_t               error_code;
	} pcd_result_t;

endpackage

>>> sv/pcd_in_stage.sv
// Input register for command words, advanced when the result register can load.
module pcd_in_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pcd_pkg::WORD_W-1:0]  s_tdata,   // [31:0] command_word
	input  logic                        out_can_load,
	output logic                        step,
	output logic [pcd_pkg::WORD_W-1:0]  word_s1
);
	import pcd_pkg::*;

	logic valid_s1;

	// A held word moves on whenever the result side has room
	assign step     = valid_s1 && out_can_load;
	assign s_tready = !valid_s1 || out_can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1 <= s_tdata;
		end
	end

endmodule

>>> sv/pcd_decode_core.sv
// Decoder state, configuration registers and the per-word decode logic.
module pcd_decode_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pcd_pkg::WORD_W-1:0]    cfg_data,
	input  logic                          step,
	input  logic [pcd_pkg::WORD_W-1:0]    word_s1,
	output pcd_pkg::pcd_result_t          result
);
	import pcd_pkg::*;

	logic [WORD_W-1:0]  limit_q;
	logic [WORD_W-1:0]  fetch_q, fetch_d;
	logic [METH_W-1:0]  method_q, method_d;
	logic [SUBCH_W-1:0] subch_q, subch_d;
	logic [COUNT_W-1:0] remain_q, remain_d;
	logic               inc_q, inc_d;
	logic [WORD_W-1:0]  ret_q, ret_d;
	logic               in_sub_q, in_sub_d;
	logic [COUNT_W-1:0] count_q, count_d;
	err_t               err_q, err_d;
	hdr_kind_t          kind;
	logic [WORD_W-1:0]  fetch_inc;
	logic               cfg_fire;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign fetch_inc = fetch_q + FETCH_STEP;

	// Header classification, in priority order
	always_comb begin
		if ((word_s1 & OLD_JUMP_MASK) == OLD_JUMP_PAT) begin
			kind = HDR_OLD_JUMP;
		end else if (word_s1[1:0] == TAG_JUMP) begin
			kind = HDR_JUMP;
		end else if (word_s1[1:0] == TAG_CALL) begin
			kind = HDR_CALL;
		end else if (word_s1 == RETURN_WORD) begin
			kind = HDR_RETURN;
		end else if ((word_s1 & METHOD_MASK) == INC_PAT) begin
			kind = HDR_INC;
		end else if ((word_s1 & METHOD_MASK) == NONINC_PAT) begin
			kind = HDR_NONINC;
		end else begin
			kind = HDR_RESERVED;
		end
	end

	// Next state and result for the word in the input register
	always_comb begin
		fetch_d  = fetch_q;
		method_d = method_q;
		subch_d  = subch_q;
		remain_d = remain_q;
		inc_d    = inc_q;
		ret_d    = ret_q;
		in_sub_d = in_sub_q;
		count_d  = count_q;
		err_d    = err_q;

		result.method_valid        = 1'b0;
		result.method_word_address = '0;
		result.subch_id            = '0;
		result.non_incrementing    = 1'b0;
		result.method_data         = '0;

		if (err_q == ERR_NONE) begin
			if (fetch_q >= limit_q) begin
				err_d = ERR_PROTECTION;
			end else if (remain_q != '0) begin
				// Data word of an open run
				result.method_valid        = 1'b1;
				result.method_word_address = method_q;
				result.subch_id            = subch_q;
				result.non_incrementing    = !inc_q;
				result.method_data         = word_s1;
				if (inc_q) begin
					method_d = method_q + METH_W'(1);
				end
				remain_d = remain_q - COUNT_W'(1);
				count_d  = count_q + COUNT_W'(1);
				fetch_d  = fetch_inc;
			end else begin
				unique case (kind) inside
					HDR_OLD_JUMP: fetch_d = word_s1 & OLD_JUMP_ADDR;
					HDR_JUMP:     fetch_d = word_s1 & ALIGN_MASK;
					HDR_CALL: begin
						if (in_sub_q) begin
							err_d = ERR_NESTED;
						end else begin
							ret_d    = fetch_inc;
							in_sub_d = 1'b1;
							fetch_d  = word_s1 & ALIGN_MASK;
						end
					end
					HDR_RETURN: begin
						if (!in_sub_q) begin
							err_d   = ERR_NO_CALL;
							fetch_d = fetch_inc;
						end else begin
							fetch_d  = ret_q & ALIGN_MASK;
							in_sub_d = 1'b0;
						end
					end
					HDR_INC, HDR_NONINC: begin
						method_d = word_s1[12:2];
						subch_d  = word_s1[15:13];
						remain_d = word_s1[28:18];
						inc_d    = (kind == HDR_INC);
						count_d  = '0;
						fetch_d  = fetch_inc;
					end
					default: begin
						err_d   = ERR_RESERVED;
						fetch_d = fetch_inc;
					end
				endcase
			end
		end

		result.next_fetch_address = fetch_d;
		result.data_count         = count_d;
		result.error_code         = err_d;
	end

	// Configuration and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= FETCH_LIMIT_RST;
			fetch_q  <= START_ADDRESS_RST;
			method_q <= '0;
			subch_q  <= '0;
			remain_q <= '0;
			inc_q    <= 1'b0;
			ret_q    <= '0;
			in_sub_q <= 1'b0;
			count_q  <= '0;
			err_q    <= ERR_NONE;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				CFG_START_ADDRESS: fetch_q <= cfg_data;
				CFG_FETCH_LIMIT:   limit_q <= cfg_data;
				default: ;
			endcase
		end else if (step) begin
			fetch_q  <= fetch_d;
			method_q <= method_d;
			subch_q  <= subch_d;
			remain_q <= remain_d;
			inc_q    <= inc_d;
			ret_q    <= ret_d;
			in_sub_q <= in_sub_d;
			count_q  <= count_d;
			err_q    <= err_d;
		end
	end

	// A latched error freezes the fetch pointer and the error itself
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE && !cfg_fire) |=> (err_q == $past(err_q)))
		else $error("latched error changed");

	a_err_freezes_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(step && err_q != ERR_NONE && !cfg_fire) |=> (fetch_q == $past(fetch_q)))
		else $error("fetch moved after error");

	// A method entry only comes from an open run and uses one count
	a_run_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.method_valid && !cfg_fire)
			|=> (remain_q == $past(remain_q) - COUNT_W'(1)))
		else $error("run count not decremented");

	a_entry_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		result.method_valid |-> (remain_q != '0 && err_q == ERR_NONE))
		else $error("method entry outside a run");

endmodule

>>> sv/pcd_out_stage.sv
// Result register feeding the master-side stream.
module pcd_out_stage (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  pcd_pkg::pcd_result_t              result,
	output logic                              out_can_load,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] next_fetch_address, [42:32] method_word_address,
	// [45:43] subch_id, [46] non_incrementing, [78:47] method_data,
	// [89:79] data_count, [92:90] error_code, [95:93] zero
	output logic [pcd_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                              m_tuser     // [0] method_valid
);
	import pcd_pkg::*;

	pcd_result_t res_s2;

	assign out_can_load = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_can_load) begin
			m_tvalid <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= result;
		end
	end

	// Pack the beat, first field lowest
	assign m_tdata = {{OUT_PAD_W{1'b0}},
	                  res_s2.error_code,
	                  res_s2.data_count,
	                  res_s2.method_data,
	                  res_s2.non_incrementing,
	                  res_s2.subch_id,
	                  res_s2.method_word_address,
	                  res_s2.next_fetch_address};
	assign m_tuser = res_s2.method_valid;

endmodule

>>> sv/pushbuffer_command_decoder_unit.sv
// Pushbuffer command decoder: one command word in, one result beat out.
// An accepted word passes the input register, then the result register;
// decode sits between them in a single pass, which also closes the state loop.
// Throughput: one word per cycle unless m_tready stalls the result register.
// Reset (arst_n low): fetch pointer to start address 0, limit all ones, no run,
// no subroutine, no error, both stream registers empty.
module pushbuffer_command_decoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pcd_pkg::WORD_W-1:0]        s_tdata,    // [31:0] command_word
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] next_fetch_address, [42:32] method_word_address,
	// [45:43] subch_id, [46] non_incrementing, [78:47] method_data,
	// [89:79] data_count, [92:90] error_code, [95:93] zero
	output logic [pcd_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tuser,    // [0] method_valid
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pcd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pcd_pkg::WORD_W-1:0]        cfg_data
);
	import pcd_pkg::*;

	logic              step;
	logic              out_can_load;
	logic [WORD_W-1:0] word_s1;
	pcd_result_t       result;

	pcd_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.out_can_load (out_can_load),
		.step         (step),
		.word_s1      (word_s1)
	);

	pcd_decode_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.word_s1   (word_s1),
		.result    (result)
	);

	pcd_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.result       (result),
		.out_can_load (out_can_load),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule
